FILE: design/vfv_pkg.sv
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared types, constants and helpers for the voxel face visibility unit.
// ----------------------------------------------------------------------------
package vfv_pkg;

   // Chunk geometry; the edge length is a power of two so coordinates are bit
   // fields of the voxel index.
   localparam int EDGE        = 16;
   localparam int EDGE_BITS   = $clog2(EDGE);
   localparam int CELL_BITS   = 2 * EDGE_BITS;
   localparam int CUBE_BITS   = 3 * EDGE_BITS;
   localparam int PLANE_CELLS = EDGE * EDGE;
   localparam int CUBE_CELLS  = EDGE * EDGE * EDGE;
   localparam int FACE_COUNT  = 6;
   localparam int BOUND_CELLS = FACE_COUNT * PLANE_CELLS;
   localparam int BOUND_BITS  = $clog2(BOUND_CELLS);

   // Field widths of the request and result
   localparam int INDEX_BITS = 12;
   localparam int FACE_BITS  = 3;
   localparam int TYPE_BITS  = 10;
   localparam int MASK_BITS  = 6;

   // Request queue depth between front and back
   localparam int QUEUE_DEPTH = 4;

   // Read steps of one evaluation: the voxel itself, then one per face
   localparam int STEP_BITS = 3;
   localparam logic [STEP_BITS-1:0] STEP_SELF = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_LAST = 3'd6;

   // Boundary plane codes
   localparam logic [FACE_BITS-1:0] FACE_XN = 3'd0;
   localparam logic [FACE_BITS-1:0] FACE_XP = 3'd1;
   localparam logic [FACE_BITS-1:0] FACE_YN = 3'd2;
   localparam logic [FACE_BITS-1:0] FACE_YP = 3'd3;
   localparam logic [FACE_BITS-1:0] FACE_ZN = 3'd4;
   localparam logic [FACE_BITS-1:0] FACE_ZP = 3'd5;

   // Exposed-face mask bits
   localparam logic [MASK_BITS-1:0] MASK_ZN = 6'b000001;
   localparam logic [MASK_BITS-1:0] MASK_ZP = 6'b000010;
   localparam logic [MASK_BITS-1:0] MASK_XP = 6'b000100;
   localparam logic [MASK_BITS-1:0] MASK_XN = 6'b001000;
   localparam logic [MASK_BITS-1:0] MASK_YP = 6'b010000;
   localparam logic [MASK_BITS-1:0] MASK_YN = 6'b100000;

   typedef enum logic [1:0] {
      KIND_CENTER_WR = 2'd0,
      KIND_BOUND_WR  = 2'd1,
      KIND_EVAL      = 2'd2,
      KIND_UNUSED    = 2'd3
   } vfv_kind_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_CLEAR,
      OP_CENTER_WR,
      OP_BOUND_WR,
      OP_EVAL
   } vfv_op_type;

   typedef enum logic [1:0] {
      SRC_CENTER,
      SRC_BOUND,
      SRC_AIR
   } vfv_src_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LAST
   } vfv_state_type;

   typedef struct packed {
      vfv_kind_type          kind;
      logic [INDEX_BITS-1:0] voxel_index;
      logic [FACE_BITS-1:0]  face;
      logic [TYPE_BITS-1:0]  block_type;
   } vfv_req_type;

   typedef struct packed {
      logic [MASK_BITS-1:0] face_mask;
      logic                 visible;
      logic                 chunk_empty;
   } vfv_rsp_type;

   // Classified request as it travels from front to back
   typedef struct packed {
      vfv_op_type            op;
      logic [INDEX_BITS-1:0] index;
      logic [BOUND_BITS-1:0] bound_addr;
      logic                  solid;
   } vfv_cmd_type;

   // Mask bit that belongs to a boundary plane code
   function automatic logic [MASK_BITS-1:0] face_bit(input logic [FACE_BITS-1:0] f);
      logic [MASK_BITS-1:0] m;
      case (f)
         FACE_XN: m = MASK_XN;
         FACE_XP: m = MASK_XP;
         FACE_YN: m = MASK_YN;
         FACE_YP: m = MASK_YP;
         FACE_ZN: m = MASK_ZN;
         FACE_ZP: m = MASK_ZP;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

FILE: design/vfv_front.sv
// ----------------------------------------------------------------------------
// vfv_front
// Classifies incoming requests into back-end commands and range-checks them.
// ----------------------------------------------------------------------------
module vfv_front import vfv_pkg::*; (
   input  logic        push,
   output logic        full,
   input  vfv_req_type req_data,
   output logic        q_push,
   output vfv_cmd_type q_data,
   input  logic        q_full
);

   logic                  index_ok;
   logic                  face_ok;
   logic [BOUND_BITS-1:0] plane_base;

   // Range-check the index and the plane code
   assign index_ok   = ({1'b0, req_data.voxel_index} < (INDEX_BITS + 1)'(CUBE_CELLS));
   assign face_ok    = (req_data.face <= FACE_ZP);
   assign plane_base = BOUND_BITS'(req_data.face) << CELL_BITS;

   // Build the command
   always_comb begin
      q_data.index      = req_data.voxel_index;
      q_data.bound_addr = plane_base + BOUND_BITS'(req_data.voxel_index[CELL_BITS-1:0]);
      q_data.solid      = |req_data.block_type;
      case (req_data.kind)
         KIND_CENTER_WR: q_data.op = index_ok ? OP_CENTER_WR : OP_CLEAR;
         KIND_BOUND_WR:  q_data.op = face_ok ? OP_BOUND_WR : OP_NOP;
         KIND_EVAL:      q_data.op = index_ok ? OP_EVAL : OP_NOP;
         default:        q_data.op = OP_NOP;
      endcase
   end

   // Hand off to the request queue
   assign q_push = push;
   assign full   = q_full;

endmodule

FILE: design/vfv_queue.sv
// ----------------------------------------------------------------------------
// vfv_queue
// Small first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
module vfv_queue import vfv_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  vfv_cmd_type wdata,
   output logic        full,
   input  logic        pop,
   output vfv_cmd_type rdata,
   output logic        empty
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   vfv_cmd_type         slots_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slots_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: design/vfv_back.sv
// ----------------------------------------------------------------------------
// vfv_back
// Executes commands: solid-bit stores, seven-read face evaluation sequencer,
// visibility flag and the result register.
// ----------------------------------------------------------------------------
module vfv_back import vfv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  vfv_cmd_type           cmd,
   input  logic                  cmd_empty,
   output logic                  cmd_pop,
   input  logic [FACE_COUNT-1:0] neighbor_present,
   output vfv_rsp_type           rsp_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop
);

   // Solid-bit stores
   logic center_mem [CUBE_CELLS];
   logic bound_mem  [BOUND_CELLS];

   vfv_state_type          state_ff, state_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   vfv_cmd_type            cur_ff;
   logic                   rd_vld_ff;
   logic [STEP_BITS-1:0]   rd_step_ff;
   vfv_src_type            rd_src_ff;
   logic                   cen_q_ff;
   logic                   bnd_q_ff;
   logic                   self_solid_ff, self_solid_in;
   logic [MASK_BITS-1:0]   mask_ff, mask_in;
   logic                   any_visible_ff, any_visible_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   vfv_rsp_type            rsp_ff, rsp_in;

   logic                   out_free;
   logic                   take;
   logic                   start;
   logic                   issue;
   logic                   load_rsp;
   logic                   cen_we;
   logic                   bnd_we;
   logic [CUBE_BITS-1:0]   cen_raddr;
   logic [BOUND_BITS-1:0]  bnd_raddr;
   vfv_src_type            src;
   logic [FACE_BITS-1:0]   face;
   logic [EDGE_BITS-1:0]   cx, cy, cz;
   logic [CUBE_BITS-1:0]   cidx;
   logic                   on_edge;
   logic [CELL_BITS-1:0]   plane_cell;
   logic [CUBE_BITS-1:0]   nbr_addr;
   logic                   rd_air;
   logic [FACE_BITS-1:0]   rd_face;
   logic [MASK_BITS-1:0]   mask_acc;
   logic                   self_acc;
   logic [MASK_BITS-1:0]   final_mask;

   assign out_free = !rsp_valid_ff || rsp_pop;
   assign take     = (state_ff == ST_IDLE) && !cmd_empty && out_free;
   assign start    = take && (cmd.op == OP_EVAL);

   // Coordinates of the voxel under evaluation
   assign cidx = cur_ff.index[CUBE_BITS-1:0];
   assign cx   = cidx[CUBE_BITS-1 -: EDGE_BITS];
   assign cy   = cidx[CELL_BITS-1 -: EDGE_BITS];
   assign cz   = cidx[EDGE_BITS-1:0];
   assign face = FACE_BITS'(step_ff - 1'b1);

   // Select the neighbor for the current step
   always_comb begin
      on_edge    = 1'b0;
      plane_cell = {cy, cz};
      nbr_addr   = cidx;
      case (face)
         FACE_XN: begin
            on_edge    = (cx == '0);
            plane_cell = {cy, cz};
            nbr_addr   = cidx - CUBE_BITS'(PLANE_CELLS);
         end
         FACE_XP: begin
            on_edge    = (cx == EDGE_BITS'(EDGE - 1));
            plane_cell = {cy, cz};
            nbr_addr   = cidx + CUBE_BITS'(PLANE_CELLS);
         end
         FACE_YN: begin
            on_edge    = (cy == '0);
            plane_cell = {cx, cz};
            nbr_addr   = cidx - CUBE_BITS'(EDGE);
         end
         FACE_YP: begin
            on_edge    = (cy == EDGE_BITS'(EDGE - 1));
            plane_cell = {cx, cz};
            nbr_addr   = cidx + CUBE_BITS'(EDGE);
         end
         FACE_ZN: begin
            on_edge    = (cz == '0);
            plane_cell = {cx, cy};
            nbr_addr   = cidx - 1'b1;
         end
         FACE_ZP: begin
            on_edge    = (cz == EDGE_BITS'(EDGE - 1));
            plane_cell = {cx, cy};
            nbr_addr   = cidx + 1'b1;
         end
         default: begin
            on_edge    = 1'b0;
            plane_cell = {cy, cz};
            nbr_addr   = cidx;
         end
      endcase
   end

   // Fold returning read data into the mask
   assign rd_face = FACE_BITS'(rd_step_ff - 1'b1);
   always_comb begin
      case (rd_src_ff)
         SRC_CENTER: rd_air = !cen_q_ff;
         SRC_BOUND:  rd_air = !bnd_q_ff;
         SRC_AIR:    rd_air = 1'b1;
         default:    rd_air = 1'b1;
      endcase
   end
   assign mask_acc = (rd_vld_ff && (rd_step_ff != STEP_SELF) && rd_air)
                   ? (mask_ff | face_bit(rd_face)) : mask_ff;
   assign self_acc = (rd_vld_ff && (rd_step_ff == STEP_SELF)) ? cen_q_ff : self_solid_ff;
   assign final_mask = self_acc ? mask_acc : '0;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      cmd_pop        = 1'b0;
      cen_we         = 1'b0;
      bnd_we         = 1'b0;
      issue          = 1'b0;
      load_rsp       = 1'b0;
      src            = SRC_CENTER;
      cen_raddr      = cidx;
      bnd_raddr      = BOUND_BITS'(face) * BOUND_BITS'(PLANE_CELLS) + BOUND_BITS'(plane_cell);
      step_in        = step_ff;
      any_visible_in = any_visible_ff;
      rsp_in         = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd_pop = take;
            step_in = STEP_SELF;
            if (take) begin
               case (cmd.op)
                  OP_CENTER_WR: begin
                     cen_we         = 1'b1;
                     any_visible_in = 1'b0;
                  end
                  OP_CLEAR:    any_visible_in = 1'b0;
                  OP_BOUND_WR: bnd_we = 1'b1;
                  default:     any_visible_in = any_visible_ff;
               endcase
               load_rsp              = (cmd.op != OP_EVAL);
               rsp_in.face_mask      = '0;
               rsp_in.visible        = 1'b0;
               rsp_in.chunk_empty    = !any_visible_in;
            end
         end
         ST_READ: begin
            issue   = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_SELF) begin
               src       = SRC_CENTER;
               cen_raddr = cidx;
            end else if (on_edge) begin
               src = neighbor_present[face] ? SRC_BOUND : SRC_AIR;
            end else begin
               src       = SRC_CENTER;
               cen_raddr = nbr_addr;
            end
         end
         ST_LAST: begin
            load_rsp           = 1'b1;
            any_visible_in     = any_visible_ff || (final_mask != '0);
            rsp_in.face_mask   = final_mask;
            rsp_in.visible     = (final_mask != '0);
            rsp_in.chunk_empty = !any_visible_in;
         end
         default: begin
            step_in = STEP_SELF;
         end
      endcase
   end

   assign mask_in       = start ? '0 : mask_acc;
   assign self_solid_in = start ? 1'b0 : self_acc;
   assign rsp_valid_in  = load_rsp ? 1'b1 : (rsp_pop ? 1'b0 : rsp_valid_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rd_vld_ff      <= 1'b0;
         any_visible_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rd_vld_ff      <= issue;
         any_visible_ff <= any_visible_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      rd_step_ff    <= step_ff;
      rd_src_ff     <= src;
      mask_ff       <= mask_in;
      self_solid_ff <= self_solid_in;
      rsp_ff        <= rsp_in;
      if (cmd_pop) begin
         cur_ff <= cmd;
      end
   end

   // Center store: write from the queue head, registered read
   always_ff @(posedge clock) begin
      if (cen_we) begin
         center_mem[cmd.index[CUBE_BITS-1:0]] <= cmd.solid;
      end
      cen_q_ff <= center_mem[cen_raddr];
   end

   // Boundary store: write from the queue head, registered read
   always_ff @(posedge clock) begin
      if (bnd_we) begin
         bound_mem[cmd.bound_addr] <= cmd.solid;
      end
      bnd_q_ff <= bound_mem[bnd_raddr];
   end

   assign rsp_data  = rsp_ff;
   assign rsp_empty = !rsp_valid_ff;

endmodule

FILE: design/voxel_face_visibility_mask_unit.sv
// ----------------------------------------------------------------------------
// voxel_face_visibility_mask_unit
// Throughput: writes 1 per cycle while the result register is free or popped; an
// evaluate holds the back end until its seven reads, issued one at a time to the
// center store, the boundary store or neither, have been folded into the mask.
// Reset clears queues, sequencer, visibility flag and neighbor_present; voxel
// and boundary stores keep no reset value and are valid only once written.
// ----------------------------------------------------------------------------
module voxel_face_visibility_mask_unit import vfv_pkg::*; #(
   parameter int QUEUE_SLOTS = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  vfv_req_type           req_data,
   output logic                  empty,
   input  logic                  pop,
   output vfv_rsp_type           rsp_data,
   input  logic                  csr_wr_en,
   input  logic [FACE_COUNT-1:0] csr_wr_data
);

   logic [FACE_COUNT-1:0] neighbor_present_ff, neighbor_present_in;
   logic                  q_push;
   logic                  q_full;
   logic                  q_empty;
   logic                  q_pop;
   vfv_cmd_type           q_wdata;
   vfv_cmd_type           q_rdata;

   // Hold the neighbor-present register
   assign neighbor_present_in = csr_wr_en ? csr_wr_data : neighbor_present_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         neighbor_present_ff <= '0;
      end else begin
         neighbor_present_ff <= neighbor_present_in;
      end
   end

   vfv_front u_front (
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (q_wdata),
      .q_full   (q_full)
   );

   vfv_queue #(
      .DEPTH (QUEUE_SLOTS)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   vfv_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd              (q_rdata),
      .cmd_empty        (q_empty),
      .cmd_pop          (q_pop),
      .neighbor_present (neighbor_present_ff),
      .rsp_data         (rsp_data),
      .rsp_empty        (empty),
      .rsp_pop          (pop)
   );

   // A result is flagged visible exactly when its mask is nonzero
   a_visible_mask: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.visible == (rsp_data.face_mask != '0)))
      else $error("visible flag disagrees with face mask");

   // A visible request means the chunk is not empty
   a_visible_flag: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.visible) |-> !rsp_data.chunk_empty)
      else $error("visible request reported with chunk_empty set");

   // No result waits right after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> empty)
      else $error("result pending after reset");

endmodule

FILE: bench/voxel_face_visibility_mask_unit_test.sv
// ----------------------------------------------------------------------------
// voxel_face_visibility_mask_unit_test
// Self-checking bench for the voxel face visibility unit. A queue-fed driver
// pushes center writes, boundary writes and evaluate requests under random
// gaps. A monitor pops results under random stalls and checks each one
// against a local prediction of the face mask, the visible flag and the
// chunk-empty flag. Runs several neighbor_present settings, and evaluates a
// voxel only after its own cell and all six adjacent cells have been loaded.
// ----------------------------------------------------------------------------
module voxel_face_visibility_mask_unit_test import vfv_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 500;
   localparam int DRAIN_TICKS = 16;
   localparam int PHASE_ITEMS = 330;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  push        = 1'b0;
   logic                  full;
   vfv_req_type           req_data    = '0;
   logic                  empty;
   logic                  pop         = 1'b0;
   vfv_rsp_type           rsp_data;
   logic                  csr_wr_en   = 1'b0;
   logic [FACE_COUNT-1:0] csr_wr_data = '0;

   // Predicted chunk contents and flag
   logic                  chunk_solid [CUBE_CELLS];
   logic                  plane_solid [BOUND_CELLS];
   logic                  seen_visible = 1'b0;
   logic [FACE_COUNT-1:0] nbr_present  = '0;

   // Cells the stimulus has already loaded, tracked at queue time
   bit                    chunk_loaded [CUBE_CELLS];
   bit                    plane_loaded [BOUND_CELLS];
   int                    ready_voxels [$];

   vfv_req_type           pending_reqs [$];
   vfv_rsp_type           expected_masks [$];
   int                    items_queued = 0;
   int                    fail_count   = 0;
   int                    idle_cycles  = 0;
   int unsigned           send_wait    = 0;
   int unsigned           pop_wait     = 0;
   bit                    send_burst   = 1'b0;
   bit                    rcv_burst    = 1'b0;

   voxel_face_visibility_mask_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Neighbor across plane f is air at the plane cell: missing chunk or air
   function automatic logic plane_air(int f, int plane_cell);
      return !nbr_present[f] || !plane_solid[f * PLANE_CELLS + plane_cell];
   endfunction

   // Apply one accepted request to the predicted chunk and form its result
   function automatic vfv_rsp_type predict_face_mask(vfv_req_type r);
      vfv_rsp_type          res;
      logic [MASK_BITS-1:0] m;
      int                   idx, x, y, z;
      m   = '0;
      idx = int'(r.voxel_index);
      x   = idx / PLANE_CELLS;
      y   = (idx / EDGE) % EDGE;
      z   = idx % EDGE;
      case (r.kind)
         KIND_CENTER_WR: begin
            if (idx < CUBE_CELLS) chunk_solid[idx] = (r.block_type != '0);
            seen_visible = 1'b0;
         end
         KIND_BOUND_WR: begin
            if (r.face < FACE_COUNT)
               plane_solid[int'(r.face) * PLANE_CELLS + idx % PLANE_CELLS] = (r.block_type != '0);
         end
         KIND_EVAL: begin
            if (idx < CUBE_CELLS && chunk_solid[idx]) begin
               if (x == 0 ? plane_air(FACE_XN, y * EDGE + z) : !chunk_solid[idx - PLANE_CELLS])
                  m |= MASK_XN;
               if (x == EDGE - 1 ? plane_air(FACE_XP, y * EDGE + z) : !chunk_solid[idx + PLANE_CELLS])
                  m |= MASK_XP;
               if (y == 0 ? plane_air(FACE_YN, x * EDGE + z) : !chunk_solid[idx - EDGE])
                  m |= MASK_YN;
               if (y == EDGE - 1 ? plane_air(FACE_YP, x * EDGE + z) : !chunk_solid[idx + EDGE])
                  m |= MASK_YP;
               if (z == 0 ? plane_air(FACE_ZN, x * EDGE + y) : !chunk_solid[idx - 1])
                  m |= MASK_ZN;
               if (z == EDGE - 1 ? plane_air(FACE_ZP, x * EDGE + y) : !chunk_solid[idx + 1])
                  m |= MASK_ZP;
               if (m != '0) seen_visible = 1'b1;
            end
         end
         default: ;
      endcase
      res.face_mask   = m;
      res.visible     = (m != '0);
      res.chunk_empty = !seen_visible;
      return res;
   endfunction

   // Queue one request and record which cell it loads
   function automatic void queue_req(vfv_kind_type k, int idx, int f, int bt);
      vfv_req_type r;
      r.kind        = k;
      r.voxel_index = INDEX_BITS'(idx);
      r.face        = FACE_BITS'(f);
      r.block_type  = TYPE_BITS'(bt);
      pending_reqs = {pending_reqs, r};
      if (k == KIND_CENTER_WR) chunk_loaded[idx % CUBE_CELLS] = 1'b1;
      if (k == KIND_BOUND_WR && f < FACE_COUNT) plane_loaded[f * PLANE_CELLS + idx % PLANE_CELLS] = 1'b1;
      if (k != KIND_UNUSED && !(k == KIND_BOUND_WR && f >= FACE_COUNT)) items_queued++;
   endfunction

   function automatic void queue_eval(int idx);
      queue_req(KIND_EVAL, idx, $urandom_range(0, 7), $urandom_range(0, 1023));
   endfunction

   function automatic int pick_type(int air_pct);
      return ($urandom_range(0, 99) < air_pct) ? 0 : $urandom_range(1, 1023);
   endfunction

   function automatic int edge_coord();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return EDGE - 1;
         default: return $urandom_range(0, EDGE - 1);
      endcase
   endfunction

   // Load one adjacent cell: a boundary cell at the chunk edge, else a voxel
   function automatic void load_side(logic at_edge, int f, int plane_cell, int nidx,
                                     int air_pct);
      if (at_edge) begin
         if (!plane_loaded[f * PLANE_CELLS + plane_cell] || $urandom_range(0, 2) == 0)
            queue_req(KIND_BOUND_WR, $urandom_range(0, 15) * PLANE_CELLS + plane_cell, f,
                      pick_type(air_pct));
      end else if (!chunk_loaded[nidx] || $urandom_range(0, 2) == 0) begin
         queue_req(KIND_CENTER_WR, nidx, $urandom_range(0, 7), pick_type(air_pct));
      end
   endfunction

   // Load a voxel and everything an evaluate of it reads
   function automatic void load_neighborhood(int idx, int air_pct);
      int x, y, z;
      x = idx / PLANE_CELLS;
      y = (idx / EDGE) % EDGE;
      z = idx % EDGE;
      if (!chunk_loaded[idx] || $urandom_range(0, 1) == 0)
         queue_req(KIND_CENTER_WR, idx, $urandom_range(0, 7), pick_type(air_pct));
      load_side(x == 0,        FACE_XN, y * EDGE + z, idx - PLANE_CELLS, air_pct);
      load_side(x == EDGE - 1, FACE_XP, y * EDGE + z, idx + PLANE_CELLS, air_pct);
      load_side(y == 0,        FACE_YN, x * EDGE + z, idx - EDGE,        air_pct);
      load_side(y == EDGE - 1, FACE_YP, x * EDGE + z, idx + EDGE,        air_pct);
      load_side(z == 0,        FACE_ZN, x * EDGE + y, idx - 1,           air_pct);
      load_side(z == EDGE - 1, FACE_ZP, x * EDGE + y, idx + 1,           air_pct);
      ready_voxels = {ready_voxels, idx};
   endfunction

   // Wait until every request is sent and answered, then let the pipe empty
   task automatic settle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || push || expected_masks.size() != 0);
      repeat (DRAIN_TICKS) @(posedge clock);
   endtask

   task automatic write_neighbors(logic [FACE_COUNT-1:0] v);
      settle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      nbr_present  = v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   // Request driver: present queued requests, hold on full, idle a random gap, possibly none, between them
   always @(posedge clock) begin : request_driver
      int unsigned gap;
      if (reset) begin
         push      <= 1'b0;
         send_wait <= 0;
      end else begin
         if (push && !full) expected_masks = {expected_masks, predict_face_mask(req_data)};
         if (push && full) begin
            // hold the request until it is taken
         end else if (send_wait != 0) begin
            push      <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (pending_reqs.size() != 0) begin
            if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
            gap        = send_burst ? 0 : $urandom_range(0, 7);
            req_data  <= pending_reqs.pop_front();
            push      <= 1'b1;
            send_wait <= gap;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Result monitor: pop with random stalls, compare against the oldest prediction
   always @(posedge clock) begin : result_monitor
      vfv_rsp_type want;
      int unsigned stall;
      if (reset) begin
         pop      <= 1'b0;
         pop_wait <= 0;
      end else if (pop && !empty) begin
         if (expected_masks.size() == 0) begin
            $error("result with no request outstanding: %0h", rsp_data);
            fail_count++;
         end else begin
            want = expected_masks.pop_front();
            if (rsp_data.face_mask !== want.face_mask) begin
               $error("face_mask: expected %0h, actual %0h", want.face_mask, rsp_data.face_mask);
               fail_count++;
            end
            if (rsp_data.visible !== want.visible) begin
               $error("visible: expected %0b, actual %0b", want.visible, rsp_data.visible);
               fail_count++;
            end
            if (rsp_data.chunk_empty !== want.chunk_empty) begin
               $error("chunk_empty: expected %0b, actual %0b", want.chunk_empty,
                      rsp_data.chunk_empty);
               fail_count++;
            end
         end
         if ($urandom_range(0, 63) == 0) rcv_burst = !rcv_burst;
         stall     = rcv_burst ? 0 : $urandom_range(0, 7);
         pop_wait <= stall;
         pop      <= (stall == 0);
      end else if (pop_wait != 0) begin
         pop_wait <= pop_wait - 1;
         pop      <= (pop_wait == 1);
      end else begin
         pop <= 1'b1;
      end
   end

   // Watchdog: end the run when no request or result moves for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      int pick, vox, target;
      logic [FACE_COUNT-1:0] cfg;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: both corner voxels with every neighbor chunk present
      write_neighbors(6'h3F);
      queue_req(KIND_CENTER_WR, 0, 0, 1023);
      queue_req(KIND_CENTER_WR, PLANE_CELLS, 7, 0);
      queue_req(KIND_CENTER_WR, EDGE, 0, 1);
      queue_req(KIND_CENTER_WR, 1, 0, 0);
      queue_req(KIND_BOUND_WR, 0, FACE_XN, 1);
      queue_req(KIND_BOUND_WR, 12'hF00, FACE_YN, 0);
      queue_req(KIND_BOUND_WR, 0, FACE_ZN, 1023);
      queue_eval(0);
      queue_req(KIND_CENTER_WR, CUBE_CELLS - 1, 0, 1023);
      queue_req(KIND_CENTER_WR, CUBE_CELLS - 1 - PLANE_CELLS, 0, 341);
      queue_req(KIND_CENTER_WR, CUBE_CELLS - 1 - EDGE, 0, 682);
      queue_req(KIND_CENTER_WR, CUBE_CELLS - 2, 0, 0);
      queue_req(KIND_BOUND_WR, PLANE_CELLS - 1, FACE_XP, 0);
      queue_req(KIND_BOUND_WR, CUBE_CELLS - 1, FACE_YP, 1);
      queue_req(KIND_BOUND_WR, PLANE_CELLS - 1, FACE_ZP, 1);
      queue_eval(CUBE_CELLS - 1);
      queue_eval(0);
      // unused kind and out-of-range planes change nothing
      queue_req(KIND_UNUSED, CUBE_CELLS - 1, 7, 1023);
      queue_req(KIND_BOUND_WR, 0, 7, 0);
      queue_req(KIND_BOUND_WR, CUBE_CELLS - 1, 6, 1023);
      // a center write clears the flag; an air voxel answers zero
      queue_req(KIND_CENTER_WR, 0, 0, 0);
      queue_eval(0);
      queue_eval(CUBE_CELLS - 1);
      queue_req(KIND_CENTER_WR, CUBE_CELLS - 2, 0, 5);
      queue_eval(CUBE_CELLS - 1);
      ready_voxels = {ready_voxels, 0};
      ready_voxels = {ready_voxels, CUBE_CELLS - 1};

      // Random phases, one neighbor_present setting each
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       cfg = '0;
            1:       cfg = '1;
            default: cfg = FACE_COUNT'($urandom_range(0, 63));
         endcase
         write_neighbors(cfg);
         target = items_queued + PHASE_ITEMS;
         while (items_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               if ($urandom_range(0, 1) == 0)
                  vox = edge_coord() * PLANE_CELLS + edge_coord() * EDGE + edge_coord();
               else
                  vox = $urandom_range(0, CUBE_CELLS - 1);
               load_neighborhood(vox, $urandom_range(0, 3) * 25);
               repeat ($urandom_range(1, 3)) queue_eval(vox);
            end else if (pick < 75) begin
               queue_eval(ready_voxels[$urandom_range(0, ready_voxels.size() - 1)]);
            end else if (pick < 85) begin
               queue_req(KIND_CENTER_WR, $urandom_range(0, CUBE_CELLS - 1), $urandom_range(0, 7),
                         pick_type(50));
            end else if (pick < 93) begin
               queue_req(KIND_BOUND_WR, $urandom_range(0, CUBE_CELLS - 1),
                         $urandom_range(0, FACE_COUNT - 1), pick_type(50));
            end else if (pick < 97) begin
               queue_req(KIND_BOUND_WR, $urandom_range(0, CUBE_CELLS - 1), $urandom_range(6, 7),
                         $urandom_range(0, 1023));
            end else begin
               queue_req(KIND_UNUSED, $urandom_range(0, CUBE_CELLS - 1), $urandom_range(0, 7),
                         $urandom_range(0, 1023));
            end
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
